// File: rtl/mxe_pkg.sv
// mxe_pkg: shared types and elaboration-time constants for the motor mixer
// no dependencies; used by every module of the mixer
package mxe_pkg;

   localparam int LogStages  = 16;
   localparam int ExpStages  = 16;
   localparam int PipeDepth  = 37;

   // per-item side data that travels beside the curve datapath
   typedef struct packed {
      logic        neg;
      logic        mag_zero;
      logic        exp_zero;
      logic [15:0] rot_x;
      logic [15:0] rot_y;
      logic [15:0] rot_z;
   } mxe_side_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] val;
      logic [63:0] res;
      logic [63:0] bitv;
      val  = v;
      res  = 64'd0;
      bitv = 64'd1 << 62;
      for (int j = 0; j < 32; j++) begin
         if (val >= res + bitv) begin
            val = val - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // 2^(-2^-i) in q30
   function automatic logic [30:0] exp_coef(input int i);
      logic [63:0] c;
      c = 64'd1 << 29;
      for (int j = 1; j <= i; j++) begin
         c = isqrt64(c << 30);
      end
      return c[30:0];
   endfunction

   // log2 in q.16, evaluated only on constants
   function automatic logic [19:0] log2_q16(input logic [14:0] x);
      logic [3:0]  k;
      logic [15:0] fr;
      logic [63:0] z;
      k = 4'd0;
      for (int j = 0; j < 15; j++) begin
         if (x[j]) k = 4'(j);
      end
      z  = 64'(x) << (30 - k);
      fr = 16'd0;
      for (int j = 0; j < 16; j++) begin
         z  = (z * z) >> 30;
         fr = {fr[14:0], 1'b0};
         if (z >= (64'd1 << 31)) begin
            fr[0] = 1'b1;
            z     = z >> 1;
         end
      end
      return {k, fr};
   endfunction

   localparam logic [19:0] LogFull = log2_q16(15'h7fff);

endpackage

// File: rtl/quad_x_motor_mixer_expo_throttle.sv
// quad_x_motor_mixer_expo_throttle: top level of the x-frame motor mixer
// depends on mxe_pkg, mxe_log, mxe_exp, mxe_mix
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | throttle, roll, pitch, yaw commands
//   rsp     | out       | rsp_valid/rsp_stall  | four motor drive values
//   csr     | in/out    | psel/penable/pready  | exponent, gain, threshold shift
//
// one command per cycle while the result side is not stalled, through 37 register stages
// most of those stages are the 16 log2 squaring stages and the 16 exp2 multiply stages
// each stage holds its item only while the next stage is full and stalled,
// so bubbles close up and the input stalls only with every stage full and the result stalled
// synchronous active-high reset clears stage valids and loads the csr defaults (exponent 4096, gain 256, shift 0)
module quad_x_motor_mixer_expo_throttle #(
   parameter int HOVER_LEVEL = 16384
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_throttle_cmd,
   input  logic [15:0] req_roll_cmd,
   input  logic [15:0] req_pitch_cmd,
   input  logic [15:0] req_yaw_cmd,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_front_left,
   output logic [15:0] rsp_front_right,
   output logic [15:0] rsp_back_left,
   output logic [15:0] rsp_back_right,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import mxe_pkg::*;

   localparam logic [1:0] RegExponent = 2'd0;
   localparam logic [1:0] RegGain     = 2'd1;
   localparam logic [1:0] RegShift    = 2'd2;

   // first register stage numbers of the exp and mix datapath sections
   localparam int ExpFirst = LogStages + 1;
   localparam int MixFirst = ExpFirst + ExpStages + 2;

   logic [15:0] exponent_ff;
   logic [15:0] gain_ff;
   logic [15:0] shift_ff;
   logic        csr_write;
   logic [15:0] thr;

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         exponent_ff <= 16'd4096;
         gain_ff     <= 16'd256;
         shift_ff    <= 16'd0;
      end else if (csr_write && paddr[1:0] == 2'b00) begin
         case (paddr[3:2])
            RegExponent: exponent_ff <= pwdata[15:0];
            RegGain:     gain_ff     <= pwdata[15:0];
            RegShift:    shift_ff    <= pwdata[15:0];
            default:     ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         RegExponent: prdata = {16'd0, exponent_ff};
         RegGain:     prdata = {16'd0, gain_ff};
         RegShift:    prdata = {16'd0, shift_ff};
         default:     prdata = 32'd0;
      endcase
   end

   // hover threshold wraps to 16 bits
   assign thr = 16'(HOVER_LEVEL) + shift_ff;

   // ---------------- pipeline control ----------------
   // a stage loads when it is empty or its item moves on this cycle
   logic [PipeDepth-1:0] valid_ff;
   logic [PipeDepth:0]   ready;

   always_comb begin
      ready[PipeDepth] = !rsp_stall;
      for (int i = PipeDepth - 1; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ready[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int i = 1; i < PipeDepth; i++) begin
            if (ready[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   assign req_stall = !ready[0];
   assign rsp_valid = valid_ff[PipeDepth-1];

   // ---------------- rotation scaling at entry ----------------
   function automatic logic [15:0] scale_rot(input logic [15:0] rot, input logic [15:0] gain);
      logic signed [31:0] prod;
      logic signed [31:0] quot;
      logic        [31:0] mag;
      prod = 32'(signed'(rot)) * 32'(signed'(gain));
      mag  = prod[31] ? 32'(-prod) : 32'(prod);
      quot = prod[31] ? -signed'(32'(mag >> 8)) : signed'(32'(mag >> 8));
      if (quot > 32'sd32767) begin
         return 16'h7fff;
      end else if (quot < -32'sd32768) begin
         return 16'h8000;
      end
      return quot[15:0];
   endfunction

   mxe_side_type side_in;
   mxe_side_type side_ff [0:MixFirst];

   always_comb begin
      side_in.neg      = req_throttle_cmd[15];
      side_in.mag_zero = (req_throttle_cmd == 16'h0000) || (req_throttle_cmd == 16'hffff);
      side_in.exp_zero = (exponent_ff == 16'd0);
      side_in.rot_x    = scale_rot(req_roll_cmd, gain_ff);
      side_in.rot_y    = scale_rot(req_pitch_cmd, gain_ff);
      side_in.rot_z    = scale_rot(req_yaw_cmd, gain_ff);
   end

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         side_ff[0] <= side_in;
      end
      for (int i = 1; i <= MixFirst; i++) begin
         if (ready[i]) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // ---------------- datapath sections ----------------
   logic [3:0]  log_k;
   logic [15:0] log_frac;
   logic [16:0] power;

   mxe_log u_log (
      .clock        (clock),
      .stage_en     (ready[LogStages:0]),
      .throttle_cmd (req_throttle_cmd),
      .log_k        (log_k),
      .log_frac     (log_frac)
   );

   mxe_exp u_exp (
      .clock          (clock),
      .stage_en       (ready[MixFirst-1:ExpFirst]),
      .curve_exponent (exponent_ff),
      .log_k          (log_k),
      .log_frac       (log_frac),
      .mag_zero       (side_ff[MixFirst-2].mag_zero),
      .exp_zero       (side_ff[MixFirst-2].exp_zero),
      .power          (power)
   );

   mxe_mix u_mix (
      .clock       (clock),
      .stage_en    (ready[MixFirst+1:MixFirst]),
      .power       (power),
      .thr         (thr),
      .side_base   (side_ff[MixFirst-1]),
      .side_out    (side_ff[MixFirst]),
      .front_left  (rsp_front_left),
      .front_right (rsp_front_right),
      .back_left   (rsp_back_left),
      .back_right  (rsp_back_right)
   );

   // ---------------- assertions ----------------
   a_reset_empties: assert property (@(posedge clock) reset |=> valid_ff == '0)
      else $error("pipeline not empty after reset");

   a_free_output_no_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled while output side is free");

   a_stall_needs_full_entry: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> valid_ff[0] && rsp_valid)
      else $error("input stalled with an empty entry stage");

   a_item_advances: assert property (@(posedge clock) disable iff (reset)
      valid_ff[0] && !req_stall |=> valid_ff[1])
      else $error("item lost between the first two stages");

endmodule

// File: rtl/mxe_log.sv
// mxe_log: leading-one normalize and sixteen squaring stages for log2 of the throttle magnitude (-t-1 when negative)
// depends on mxe_pkg
module mxe_log (
   input  logic        clock,
   input  logic [16:0] stage_en,
   input  logic [15:0] throttle_cmd,
   output logic [3:0]  log_k,
   output logic [15:0] log_frac
);
   import mxe_pkg::*;

   logic [14:0] mag;
   logic [3:0]  k_in;
   logic [30:0] z_in;

   logic [30:0] z_ff    [0:16];
   logic [15:0] frac_ff [0:16];
   logic [3:0]  k_ff    [0:16];

   // negative throttle uses -t-1, which is the bitwise inverse
   assign mag = throttle_cmd[15] ? ~throttle_cmd[14:0] : throttle_cmd[14:0];

   always_comb begin
      k_in = 4'd0;
      for (int i = 0; i < 15; i++) begin
         if (mag[i]) k_in = 4'(i);
      end
      z_in = 31'({16'd0, mag} << (5'd30 - {1'b0, k_in}));
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         z_ff[0]    <= z_in;
         frac_ff[0] <= 16'd0;
         k_ff[0]    <= k_in;
      end
   end

   for (genvar g = 1; g <= LogStages; g++) begin : g_sq
      logic [61:0] sq;
      logic [31:0] sq_sh;
      assign sq    = 62'(z_ff[g-1]) * 62'(z_ff[g-1]);
      assign sq_sh = sq[61:30];
      always_ff @(posedge clock) begin
         if (stage_en[g]) begin
            z_ff[g]    <= sq_sh[31] ? sq_sh[31:1] : sq_sh[30:0];
            frac_ff[g] <= {frac_ff[g-1][14:0], sq_sh[31]};
            k_ff[g]    <= k_ff[g-1];
         end
      end
   end

   assign log_k    = k_ff[16];
   assign log_frac = frac_ff[16];

endmodule

// File: rtl/mxe_exp.sv
// mxe_exp: exponent scaling and sixteen constant-multiply stages for 2^-n
// depends on mxe_pkg
module mxe_exp (
   input  logic        clock,
   input  logic [17:0] stage_en,
   input  logic [15:0] curve_exponent,
   input  logic [3:0]  log_k,
   input  logic [15:0] log_frac,
   input  logic        mag_zero,
   input  logic        exp_zero,
   output logic [16:0] power
);
   import mxe_pkg::*;

   logic [19:0] lm;
   logic [19:0] dlog;
   logic [35:0] prod_n;

   logic        big_ff;
   logic [4:0]  ip_ff;
   logic [15:0] f_ff;
   logic [30:0] r_ff [0:16];
   logic [16:0] power_ff;

   assign lm     = {log_k, log_frac};
   assign dlog   = (lm > LogFull) ? 20'd0 : LogFull - lm;
   assign prod_n = 36'(dlog) * 36'(curve_exponent);

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         big_ff <= (prod_n[35:28] > 8'd16);
         ip_ff  <= prod_n[32:28];
         f_ff   <= prod_n[27:12];
      end
   end

   assign r_ff[0] = 31'd1 << 30;

   logic [4:0]  ip_d  [0:16];
   logic        big_d [0:16];
   logic [15:0] f_d   [0:16];
   assign ip_d[0]  = ip_ff;
   assign big_d[0] = big_ff;
   assign f_d[0]   = f_ff;

   for (genvar g = 1; g <= ExpStages; g++) begin : g_mul
      localparam logic [30:0] Coef = exp_coef(g);
      logic [61:0] prod;
      logic [4:0]  ip_r;
      logic        big_r;
      logic [15:0] f_r;
      logic [30:0] r_r;
      assign prod = 62'(r_ff[g-1]) * 62'(Coef);
      always_ff @(posedge clock) begin
         if (stage_en[g]) begin
            r_r   <= f_d[g-1][16-g] ? prod[60:30] : r_ff[g-1];
            ip_r  <= ip_d[g-1];
            big_r <= big_d[g-1];
            f_r   <= f_d[g-1];
         end
      end
      assign r_ff[g]  = r_r;
      assign ip_d[g]  = ip_r;
      assign big_d[g] = big_r;
      assign f_d[g]   = f_r;
   end

   always_ff @(posedge clock) begin
      if (stage_en[17]) begin
         if (exp_zero) begin
            power_ff <= 17'h10000;
         end else if (mag_zero || big_d[16]) begin
            power_ff <= 17'd0;
         end else begin
            power_ff <= 17'(r_ff[16] >> (6'd14 + {1'b0, ip_d[16]}));
         end
      end
   end

   assign power = power_ff;

endmodule

// File: rtl/mxe_mix.sv
// mxe_mix: base speed around the threshold and the x-frame motor mix
// depends on mxe_pkg
module mxe_mix (
   input  logic                      clock,
   input  logic [1:0]                stage_en,
   input  logic [16:0]               power,
   input  logic [15:0]               thr,
   input  mxe_pkg::mxe_side_type     side_base,
   input  mxe_pkg::mxe_side_type     side_out,
   output logic [15:0]               front_left,
   output logic [15:0]               front_right,
   output logic [15:0]               back_left,
   output logic [15:0]               back_right
);
   import mxe_pkg::*;

   logic [15:0] room;
   logic [32:0] up_prod;
   logic [33:0] dn_prod;
   logic [15:0] base_in;
   logic [15:0] base_ff;
   logic [15:0] fl_ff;
   logic [15:0] fr_ff;
   logic [15:0] bl_ff;
   logic [15:0] br_ff;

   assign room    = 16'hffff - thr;
   assign up_prod = 33'(room) * 33'(power);
   assign dn_prod = 34'(33'(thr) * 33'(power)) + 34'd65535;
   assign base_in = side_base.neg ? thr - dn_prod[31:16] : thr + up_prod[31:16];

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         base_ff <= base_in;
      end
      if (stage_en[1]) begin
         fl_ff <= base_ff + side_out.rot_y + side_out.rot_x - side_out.rot_z;
         fr_ff <= base_ff - side_out.rot_y + side_out.rot_x + side_out.rot_z;
         bl_ff <= base_ff + side_out.rot_y - side_out.rot_x + side_out.rot_z;
         br_ff <= base_ff - side_out.rot_y - side_out.rot_x - side_out.rot_z;
      end
   end

   assign front_left  = fl_ff;
   assign front_right = fr_ff;
   assign back_left   = bl_ff;
   assign back_right  = br_ff;

endmodule

// File: dv/tb_top.sv
// tb_top: self-checking testbench for the quad x motor mixer with expo throttle
// depends on rtl/mxe_pkg.sv and rtl/quad_x_motor_mixer_expo_throttle.sv
// directed table then random phases, results checked against typed rows or a predictor
`timescale 1ns / 1ps

module tb_top;

   localparam int HoverLevel = 16384;
   localparam int DrainCycles = 60;   // more than the 37 stage pipeline depth

   // register byte addresses, 4 bytes apart
   localparam logic [3:0] AddrExponent = 4'd0;
   localparam logic [3:0] AddrGain     = 4'd4;
   localparam logic [3:0] AddrShift    = 4'd8;
   localparam logic [3:0] AddrUnused   = 4'd12;

   typedef struct packed {
      logic [15:0] fl;
      logic [15:0] fr;
      logic [15:0] bl;
      logic [15:0] br;
   } motor_set_type;

   typedef struct {
      logic [15:0] e;
      logic [15:0] g;
      logic [15:0] s;
      logic [15:0] t;
      logic [15:0] r;
      logic [15:0] p;
      logic [15:0] y;
      bit          typed;
      motor_set_type motors;
   } dir_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [15:0] req_throttle_cmd;
   logic [15:0] req_roll_cmd;
   logic [15:0] req_pitch_cmd;
   logic [15:0] req_yaw_cmd;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_front_left;
   logic [15:0] rsp_front_right;
   logic [15:0] rsp_back_left;
   logic [15:0] rsp_back_right;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   // local copy of the register file used by the predictor
   logic [15:0] cur_exponent;
   logic [15:0] cur_gain;
   logic [15:0] cur_shift;

   motor_set_type motor_q[$];
   int         fail_count;
   int         stall_mode;

   quad_x_motor_mixer_expo_throttle #(
      .HOVER_LEVEL(HoverLevel)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_throttle_cmd(req_throttle_cmd),
      .req_roll_cmd    (req_roll_cmd),
      .req_pitch_cmd   (req_pitch_cmd),
      .req_yaw_cmd     (req_yaw_cmd),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_front_left  (rsp_front_left),
      .rsp_front_right (rsp_front_right),
      .rsp_back_left   (rsp_back_left),
      .rsp_back_right  (rsp_back_right),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   // 4 ns clock
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------- predictor ----------------

   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] val;
      logic [63:0] res;
      logic [63:0] bitv;
      val  = v;
      res  = 64'd0;
      bitv = 64'd1 << 62;
      while (bitv > val) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (val >= res + bitv) begin
            val = val - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // log2 in q.16: integer part from the leading one, fraction by squaring
   function automatic logic [19:0] log2_fix(input logic [14:0] x);
      int          k;
      logic [63:0] z;
      logic [15:0] fr;
      k = 0;
      while (k < 15 && (x >> (k + 1)) != 0) k++;
      z  = 64'(x) << (30 - k);
      fr = 16'd0;
      for (int i = 0; i < 16; i++) begin
         z  = (z * z) >> 30;
         fr = {fr[14:0], 1'b0};
         if (z >= (64'd1 << 31)) begin
            fr[0] = 1'b1;
            z     = z >> 1;
         end
      end
      return {k[3:0], fr};
   endfunction

   // 2^-n, n in q.16, result q16
   function automatic logic [31:0] exp2_neg_fix(input logic [63:0] n);
      logic [63:0] ip;
      logic [15:0] f;
      logic [63:0] c;
      logic [63:0] r;
      ip = n >> 16;
      f  = n[15:0];
      c  = 64'd1 << 29;
      r  = 64'd1 << 30;
      if (ip > 16) return 32'd0;
      for (int i = 1; i <= 16; i++) begin
         c = int_sqrt(c << 30);
         if (f[16 - i]) r = (r * c) >> 30;
      end
      return 32'(r >> (14 + ip));
   endfunction

   function automatic logic [31:0] curve_power(input logic [14:0] m, input logic [15:0] e);
      logic [19:0] lf;
      logic [19:0] lm;
      logic [19:0] d;
      if (e == 0) return 32'd65536;   // zero exponent: full power even at zero
      if (m == 0) return 32'd0;
      lf = log2_fix(15'h7fff);
      lm = log2_fix(m);
      d  = (lm > lf) ? 20'd0 : lf - lm;
      return exp2_neg_fix((64'(d) * 64'(e)) >> 12);
   endfunction

   // gain scaling, truncation toward zero, then 16 bit saturation
   function automatic logic [15:0] scale_rotation(input logic [15:0] rot, input logic [15:0] g);
      int rs;
      int gs;
      int pr;
      int q;
      rs = $signed(rot);
      gs = $signed(g);
      pr = rs * gs;
      q  = (pr < 0) ? -((-pr) >>> 8) : (pr >>> 8);
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
   endfunction

   function automatic motor_set_type mix_motors(input logic [15:0] t, input logic [15:0] roll,
                                                input logic [15:0] pitch,
                                                input logic [15:0] yaw);
      logic [15:0] thr;
      logic [14:0] m;
      logic [31:0] pw;
      logic [31:0] base;
      logic [15:0] rx;
      logic [15:0] ry;
      logic [15:0] rz;
      motor_set_type ms;
      thr = 16'(HoverLevel + cur_shift);   // wraps to 16 bits
      m   = t[15] ? ~t[14:0] : t[14:0];    // -t-1 for negative throttle
      pw  = curve_power(m, cur_exponent);
      if (!t[15])
         base = 32'(thr) + 32'((64'(16'hffff - thr) * 64'(pw)) >> 16);
      else
         base = 32'(thr) - 32'((64'(thr) * 64'(pw) + 64'd65535) >> 16);
      rx = scale_rotation(roll, cur_gain);
      ry = scale_rotation(pitch, cur_gain);
      rz = scale_rotation(yaw, cur_gain);
      ms.fl = 16'(base + ry + rx - rz);
      ms.fr = 16'(base - ry + rx + rz);
      ms.bl = 16'(base + ry - rx + rz);
      ms.br = 16'(base - ry - rx - rz);
      return ms;
   endfunction

   // ---------------- csr access ----------------

   task automatic csr_write(input logic [3:0] addr, input logic [15:0] value);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= addr;
      pwdata  <= {16'hdead, value};   // upper bits must be ignored
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);               // register written at this edge
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (addr)
         AddrExponent: cur_exponent = value;
         AddrGain:     cur_gain     = value;
         AddrShift:    cur_shift    = value;
         default:      ;             // unknown address: write ignored
      endcase
      @(posedge clock);               // bus idle before the next write
   endtask

   task automatic wait_drained();
      while (motor_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic set_config(input logic [15:0] e, input logic [15:0] g, input logic [15:0] s);
      wait_drained();
      csr_write(AddrExponent, e);
      csr_write(AddrGain, g);
      csr_write(AddrShift, s);
   endtask

   // ---------------- command sender ----------------

   function automatic int pick_gap();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 65) return 0;
      if (sel < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // one transfer on the command channel; prediction is taken at acceptance
   task automatic send_cmd(input logic [15:0] t, input logic [15:0] r, input logic [15:0] p,
                           input logic [15:0] y, input bit typed,
                           input motor_set_type typed_val);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_throttle_cmd <= t;
      req_roll_cmd     <= r;
      req_pitch_cmd    <= p;
      req_yaw_cmd      <= y;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (typed) motor_q.push_back(typed_val);
      else motor_q.push_back(mix_motors(t, r, p, y));
   endtask

   function automatic logic [15:0] rand_field();
      case ($urandom_range(0, 9))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'hffff;
         4: return 16'($urandom_range(0, 255));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] rand_exponent();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hffff;
         2: return 16'h1000;
         3: return 16'($urandom_range(0, 16'h4000));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] rand_signed_reg();
      case ($urandom_range(0, 7))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'h0100;
         3: return 16'($urandom_range(0, 16'h0400));
         default: return 16'($urandom);
      endcase
   endfunction

   // ---------------- result checker ----------------

   // random backpressure: stretches with no stall, light stall or heavy stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_mode <= 0;
      end else begin
         if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 9) < 7);
         endcase
      end
   end

   always @(posedge clock) begin
      motor_set_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (motor_q.size() == 0) begin
            $display("%0t: unexpected result %h %h %h %h", $time, rsp_front_left,
                     rsp_front_right, rsp_back_left, rsp_back_right);
            fail_count++;
         end else begin
            want = motor_q.pop_front();
            if (rsp_front_left !== want.fl) begin
               $display("%0t: front_left expected %h actual %h", $time, want.fl, rsp_front_left);
               fail_count++;
            end
            if (rsp_front_right !== want.fr) begin
               $display("%0t: front_right expected %h actual %h", $time, want.fr,
                        rsp_front_right);
               fail_count++;
            end
            if (rsp_back_left !== want.bl) begin
               $display("%0t: back_left expected %h actual %h", $time, want.bl, rsp_back_left);
               fail_count++;
            end
            if (rsp_back_right !== want.br) begin
               $display("%0t: back_right expected %h actual %h", $time, want.br,
                        rsp_back_right);
               fail_count++;
            end
         end
      end
   end

   // ---------------- main sequence ----------------

   dir_row_type dir_tab[20];

   initial begin
      motor_set_type none;
      int         pause_at;
      none             = '0;
      fail_count       = 0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_throttle_cmd = '0;
      req_roll_cmd     = '0;
      req_pitch_cmd    = '0;
      req_yaw_cmd      = '0;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      cur_exponent     = 16'h1000;
      cur_gain         = 16'h0100;
      cur_shift        = 16'h0000;

      // e, gain, shift, throttle, roll, pitch, yaw, typed, expected motors
      dir_tab = '{
         // reset settings: zero throttle with zero rotation sits at hover
         '{16'h1000, 16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1,
           {16'h4000, 16'h4000, 16'h4000, 16'h4000}},
         // full positive throttle reaches the top
         '{16'h1000, 16'h0100, 16'h0000, 16'h7fff, 16'h0000, 16'h0000, 16'h0000, 1'b1,
           {16'hffff, 16'hffff, 16'hffff, 16'hffff}},
         // full negative throttle reaches zero
         '{16'h1000, 16'h0100, 16'h0000, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 1'b1,
           {16'h0000, 16'h0000, 16'h0000, 16'h0000}},
         // minus one has zero magnitude
         '{16'h1000, 16'h0100, 16'h0000, 16'hffff, 16'h0000, 16'h0000, 16'h0000, 1'b1,
           {16'h4000, 16'h4000, 16'h4000, 16'h4000}},
         '{16'h1000, 16'h0100, 16'h0000, 16'd1000, 16'd100, 16'hff38, 16'd300, 1'b0, none},
         '{16'h1000, 16'h0100, 16'h0000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 1'b0, none},
         '{16'h1000, 16'h0100, 16'h0000, 16'h0001, 16'h8000, 16'h7fff, 16'h8000, 1'b0, none},
         // zero exponent: full power everywhere
         '{16'h0000, 16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, none},
         '{16'h0000, 16'h0100, 16'h0000, 16'hfffb, 16'h0000, 16'h0000, 16'h0000, 1'b0, none},
         '{16'h0000, 16'h0100, 16'h0000, 16'hffff, 16'h0005, 16'h0000, 16'h0000, 1'b0, none},
         // huge exponent: tiny powers below full throttle, max gain saturates, threshold 0xbfff
         '{16'hffff, 16'h7fff, 16'h7fff, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 1'b0, none},
         '{16'hffff, 16'h7fff, 16'h7fff, 16'd100, 16'h7fff, 16'h0001, 16'hffff, 1'b0, none},
         '{16'hffff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 1'b0, none},
         '{16'hffff, 16'h7fff, 16'h7fff, 16'h7ffe, 16'h0000, 16'h0000, 16'h0000, 1'b0, none},
         // most negative gain, threshold wraps below zero
         '{16'h3000, 16'h8000, 16'h8000, 16'hff9c, 16'h8000, 16'h7fff, 16'h0001, 1'b0, none},
         '{16'h3000, 16'h8000, 16'h8000, 16'd20000, 16'hffff, 16'h0002, 16'h8000, 1'b0, none},
         // zero threshold, negative unit gain, motor wrap
         '{16'h0800, 16'hff00, 16'hc000, 16'd5000, 16'h8000, 16'h8000, 16'h7fff, 1'b0, none},
         '{16'h0800, 16'hff00, 16'hc000, 16'h8001, 16'h1234, 16'hedcb, 16'h0fff, 1'b0, none},
         '{16'h0001, 16'h0080, 16'h4000, 16'd16384, 16'h0003, 16'hfffd, 16'h0001, 1'b0, none},
         '{16'h0001, 16'h0080, 16'h4000, 16'hc000, 16'hffff, 16'h0001, 16'hffff, 1'b0, none}
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table; registers rewritten whenever a row changes them
      foreach (dir_tab[i]) begin
         if (dir_tab[i].e !== cur_exponent || dir_tab[i].g !== cur_gain ||
             dir_tab[i].s !== cur_shift) begin
            req_valid <= 1'b0;
            set_config(dir_tab[i].e, dir_tab[i].g, dir_tab[i].s);
         end
         send_cmd(dir_tab[i].t, dir_tab[i].r, dir_tab[i].p, dir_tab[i].y,
                  dir_tab[i].typed, dir_tab[i].motors);
      end

      // a write to the unused address must leave the settings alone
      req_valid <= 1'b0;
      wait_drained();
      csr_write(AddrUnused, 16'h5a5a);
      repeat (20) send_cmd(rand_field(), rand_field(), rand_field(), rand_field(), 1'b0, none);

      // random phases, each under a fresh register setting
      for (int ph = 0; ph < 8; ph++) begin
         req_valid <= 1'b0;
         case (ph)
            0: set_config(16'h1000, 16'h0100, 16'h0000);
            1: set_config(16'hffff, 16'h8000, 16'h7fff);
            2: set_config(16'h0000, 16'h7fff, 16'h8000);
            default: set_config(rand_exponent(), rand_signed_reg(), rand_signed_reg());
         endcase
         pause_at = $urandom_range(20, 90);
         for (int n = 0; n < 110; n++) begin
            // hold off once per phase until the pipeline has emptied
            if (n == pause_at) begin
               req_valid <= 1'b0;
               while (motor_q.size() != 0) @(posedge clock);
            end
            send_cmd(rand_field(), rand_field(), rand_field(), rand_field(), 1'b0, none);
         end
      end

      req_valid <= 1'b0;
      wait_drained();
      if (fail_count == 0) begin
         $display("[quad_x_motor_mixer_expo_throttle] OK");
      end else begin
         $display("[quad_x_motor_mixer_expo_throttle] ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #4ms;
      $display("[quad_x_motor_mixer_expo_throttle] ERROR");
      $finish;
   end

endmodule

// File: filelist.f
rtl/mxe_pkg.sv
rtl/mxe_log.sv
rtl/mxe_exp.sv
rtl/mxe_mix.sv
rtl/quad_x_motor_mixer_expo_throttle.sv
dv/tb_top.sv
